/* rtl/core/ufct_pkg.sv */
// Shared types, constants and microcode encodings of the union-find engine.
package ufct_pkg;

  localparam int NODE_W    = 10;
  localparam int MAX_NODES = 1 << NODE_W;
  localparam int CNT_W     = NODE_W + 1;
  localparam int SIZE_W    = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_RESET = 1024;
  localparam int STEP_W    = 5;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SIZE_W-1:0] sz_t;
  typedef logic [CFG_W-1:0]  cfg_t;
  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_MERGE  = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_WALK,
    OP_RESTART,
    OP_COMPRESS,
    OP_SAVE_A,
    OP_SAVE_B,
    OP_CAP_A,
    OP_JOIN,
    OP_RD_INFO,
    OP_FIND_RES,
    OP_ZERO_RES,
    OP_CLR_INIT,
    OP_CLR_STEP,
    OP_DELIVER
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_START,
    C_CLR,
    C_BAD,
    C_WALK_MORE,
    C_COMP_MORE,
    C_FIND,
    C_SEL_B,
    C_CLR_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic walk_more;
    logic comp_more;
    logic clr_more;
    logic is_clr;
    logic is_find;
    logic is_bad;
    logic sel_b;
  } stat_t;

  typedef struct packed {
    sz_t  size;
    logic cyc;
  } info_t;

  typedef struct packed {
    node_t root;
    logic  cyc;
    sz_t   size;
    logic  joined;
  } res_t;

endpackage

/* rtl/core/ufct_seq.sv */
// Microcode sequencer: step counter, control store and conditional jumps.
module ufct_seq
  import ufct_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  logic  out_busy_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o,
  output logic  idle_o
);

  localparam step_t S_IDLE        = 5'd0;
  localparam step_t S_DISP_CLR    = 5'd1;
  localparam step_t S_DISP_BAD    = 5'd2;
  localparam step_t S_INIT        = 5'd3;
  localparam step_t S_WALK        = 5'd4;
  localparam step_t S_RESTART     = 5'd5;
  localparam step_t S_COMP        = 5'd6;
  localparam step_t S_AFTER_FIND  = 5'd7;
  localparam step_t S_AFTER_MERGE = 5'd8;
  localparam step_t S_SAVE_A      = 5'd9;
  localparam step_t S_SAVE_B      = 5'd10;
  localparam step_t S_CAP_A       = 5'd11;
  localparam step_t S_JOIN        = 5'd12;
  localparam step_t S_FIND_INFO   = 5'd13;
  localparam step_t S_FIND_RES    = 5'd14;
  localparam step_t S_ZERO        = 5'd15;
  localparam step_t S_CLR_INIT    = 5'd16;
  localparam step_t S_CLR_STEP    = 5'd17;
  localparam step_t S_CLR_DONE    = 5'd18;
  localparam step_t S_DONE        = 5'd31;

  // The done step sits at the top address so that falling through wraps to idle.
  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: S_IDLE};
    case (s)
      S_IDLE:        w = '{op: OP_NONE,     cond: C_NOT_START, target: S_IDLE};
      S_DISP_CLR:    w = '{op: OP_NONE,     cond: C_CLR,       target: S_CLR_INIT};
      S_DISP_BAD:    w = '{op: OP_NONE,     cond: C_BAD,       target: S_ZERO};
      S_INIT:        w = '{op: OP_INIT,     cond: C_NEVER,     target: S_IDLE};
      S_WALK:        w = '{op: OP_WALK,     cond: C_WALK_MORE, target: S_WALK};
      S_RESTART:     w = '{op: OP_RESTART,  cond: C_NEVER,     target: S_IDLE};
      S_COMP:        w = '{op: OP_COMPRESS, cond: C_COMP_MORE, target: S_COMP};
      S_AFTER_FIND:  w = '{op: OP_NONE,     cond: C_FIND,      target: S_FIND_INFO};
      S_AFTER_MERGE: w = '{op: OP_NONE,     cond: C_SEL_B,     target: S_SAVE_B};
      S_SAVE_A:      w = '{op: OP_SAVE_A,   cond: C_ALWAYS,    target: S_INIT};
      S_SAVE_B:      w = '{op: OP_SAVE_B,   cond: C_NEVER,     target: S_IDLE};
      S_CAP_A:       w = '{op: OP_CAP_A,    cond: C_NEVER,     target: S_IDLE};
      S_JOIN:        w = '{op: OP_JOIN,     cond: C_ALWAYS,    target: S_DONE};
      S_FIND_INFO:   w = '{op: OP_RD_INFO,  cond: C_NEVER,     target: S_IDLE};
      S_FIND_RES:    w = '{op: OP_FIND_RES, cond: C_ALWAYS,    target: S_DONE};
      S_ZERO:        w = '{op: OP_ZERO_RES, cond: C_ALWAYS,    target: S_DONE};
      S_CLR_INIT:    w = '{op: OP_CLR_INIT, cond: C_NEVER,     target: S_IDLE};
      S_CLR_STEP:    w = '{op: OP_CLR_STEP, cond: C_CLR_MORE,  target: S_CLR_STEP};
      S_CLR_DONE:    w = '{op: OP_ZERO_RES, cond: C_ALWAYS,    target: S_DONE};
      S_DONE:        w = '{op: OP_DELIVER,  cond: C_OUT_BUSY,  target: S_DONE};
      default:       w = '{op: OP_NONE,     cond: C_ALWAYS,    target: S_IDLE};
    endcase
    return w;
  endfunction

  step_t step_q, step_d;
  ctrl_t word;
  logic  take;

  always_comb begin
    word = ucode(step_q);
    case (word.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NOT_START: take = !start_i;
      C_CLR:       take = stat_i.is_clr;
      C_BAD:       take = stat_i.is_bad;
      C_WALK_MORE: take = stat_i.walk_more;
      C_COMP_MORE: take = stat_i.comp_more;
      C_FIND:      take = stat_i.is_find;
      C_SEL_B:     take = stat_i.sel_b;
      C_CLR_MORE:  take = stat_i.clr_more;
      C_OUT_BUSY:  take = out_busy_i;
      default:     take = 1'b0;
    endcase
    step_d = take ? word.target : step_q + STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = word;
  assign idle_o = (step_q == S_IDLE);

endmodule

/* rtl/core/ufct_dp.sv */
// Datapath of the union-find engine: node tables, walk registers and result.
module ufct_dp
  import ufct_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  logic [1:0] command_i,
  input  node_t node_a_i,
  input  node_t node_b_i,
  input  logic  cfg_we_i,
  input  cfg_t  cfg_wdata_i,
  input  ctrl_t ctrl_i,
  output stat_t stat_o,
  output res_t  res_o
);

  node_t parent_mem [MAX_NODES];
  info_t info_mem [MAX_NODES];

  logic [1:0] cmd_q, cmd_d;
  node_t a_q, a_d, b_q, b_d;
  logic  sel_b_q, sel_b_d;
  node_t r_q, r_d, cur_q, cur_d, ra_q, ra_d, rb_q, rb_d;
  cnt_t  steps_q, steps_d, clr_q, clr_d;
  sz_t   size_a_q, size_a_d;
  logic  cyc_a_q, cyc_a_d;
  res_t  res_q, res_d;
  cfg_t  eu_q;

  node_t p_rd_q, p_raddr, p_waddr, p_wdata;
  logic  p_we;
  info_t i_rd_q, i_wdata;
  node_t i_raddr, i_waddr;
  logic  i_we;

  node_t x;
  logic  bound, walk_more, comp_more, clr_more;
  cnt_t  clr_limit;
  logic  same, swap;
  node_t win, lose;
  logic [SIZE_W:0] sum;
  sz_t   sum_sat;
  logic  cyc_or;

  always_comb begin
    x         = sel_b_q ? b_q : a_q;
    bound     = (steps_q == CNT_W'(MAX_NODES));
    walk_more = (p_rd_q != r_q) && !bound;
    comp_more = (cur_q != r_q) && !bound;
    clr_limit = (eu_q > CFG_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : CNT_W'(eu_q);
    clr_more  = (clr_q < clr_limit);
    same      = (ra_q == rb_q);
    swap      = (size_a_q < i_rd_q.size);
    win       = swap ? rb_q : ra_q;
    lose      = swap ? ra_q : rb_q;
    sum       = {1'b0, size_a_q} + {1'b0, i_rd_q.size};
    sum_sat   = sum[SIZE_W] ? {SIZE_W{1'b1}} : sum[SIZE_W-1:0];
    cyc_or    = cyc_a_q | i_rd_q.cyc;
  end

  always_comb begin
    cmd_d    = cmd_q;
    a_d      = a_q;
    b_d      = b_q;
    sel_b_d  = sel_b_q;
    r_d      = r_q;
    cur_d    = cur_q;
    ra_d     = ra_q;
    rb_d     = rb_q;
    steps_d  = steps_q;
    clr_d    = clr_q;
    size_a_d = size_a_q;
    cyc_a_d  = cyc_a_q;
    res_d    = res_q;
    p_we     = 1'b0;
    p_waddr  = cur_q;
    p_wdata  = r_q;
    p_raddr  = x;
    i_we     = 1'b0;
    i_waddr  = ra_q;
    i_wdata  = '{size: size_a_q, cyc: 1'b1};
    i_raddr  = r_q;
    case (ctrl_i.op)
      OP_INIT, OP_RESTART: begin
        r_d     = (ctrl_i.op == OP_INIT) ? x : r_q;
        cur_d   = x;
        steps_d = '0;
        p_raddr = x;
      end
      OP_WALK: begin
        if (walk_more) begin
          r_d     = p_rd_q;
          steps_d = steps_q + CNT_W'(1);
          p_raddr = p_rd_q;
        end
      end
      OP_COMPRESS: begin
        if (comp_more) begin
          p_we    = 1'b1;
          p_waddr = cur_q;
          p_wdata = r_q;
          cur_d   = p_rd_q;
          steps_d = steps_q + CNT_W'(1);
          p_raddr = p_rd_q;
        end
      end
      OP_SAVE_A: begin
        ra_d    = r_q;
        sel_b_d = 1'b1;
      end
      OP_SAVE_B: begin
        rb_d    = r_q;
        i_raddr = ra_q;
      end
      OP_CAP_A: begin
        size_a_d = i_rd_q.size;
        cyc_a_d  = i_rd_q.cyc;
        i_raddr  = rb_q;
      end
      OP_JOIN: begin
        i_we = 1'b1;
        if (same) begin
          i_waddr = ra_q;
          i_wdata = '{size: size_a_q, cyc: 1'b1};
          res_d   = '{root: ra_q, cyc: 1'b1, size: size_a_q, joined: 1'b1};
        end else begin
          p_we    = 1'b1;
          p_waddr = lose;
          p_wdata = win;
          i_waddr = win;
          i_wdata = '{size: sum_sat, cyc: cyc_or};
          res_d   = '{root: win, cyc: cyc_or, size: sum_sat, joined: 1'b0};
        end
      end
      OP_RD_INFO: begin
        i_raddr = r_q;
      end
      OP_FIND_RES: begin
        res_d = '{root: r_q, cyc: i_rd_q.cyc, size: i_rd_q.size, joined: 1'b0};
      end
      OP_ZERO_RES: begin
        res_d = '0;
      end
      OP_CLR_INIT: begin
        clr_d = '0;
      end
      OP_CLR_STEP: begin
        if (clr_more) begin
          p_we    = 1'b1;
          p_waddr = clr_q[NODE_W-1:0];
          p_wdata = clr_q[NODE_W-1:0];
          i_we    = 1'b1;
          i_waddr = clr_q[NODE_W-1:0];
          i_wdata = '{size: SIZE_W'(1), cyc: 1'b0};
          clr_d   = clr_q + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    if (load_i) begin
      cmd_d   = command_i;
      a_d     = node_a_i;
      b_d     = node_b_i;
      sel_b_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      parent_mem[p_waddr] <= p_wdata;
    end
    p_rd_q <= parent_mem[p_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (i_we) begin
      info_mem[i_waddr] <= i_wdata;
    end
    i_rd_q <= info_mem[i_raddr];
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    a_q      <= a_d;
    b_q      <= b_d;
    r_q      <= r_d;
    cur_q    <= cur_d;
    ra_q     <= ra_d;
    rb_q     <= rb_d;
    steps_q  <= steps_d;
    clr_q    <= clr_d;
    size_a_q <= size_a_d;
    cyc_a_q  <= cyc_a_d;
    res_q    <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eu_q    <= CFG_W'(CFG_RESET);
      sel_b_q <= 1'b0;
    end else begin
      sel_b_q <= sel_b_d;
      if (cfg_we_i) begin
        eu_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    stat_o.walk_more = walk_more;
    stat_o.comp_more = comp_more;
    stat_o.clr_more  = clr_more;
    stat_o.is_clr    = (cmd_q == CMD_CLEAR);
    stat_o.is_find   = (cmd_q == CMD_FIND);
    stat_o.is_bad    = !((cmd_q == CMD_MERGE) || (cmd_q == CMD_FIND));
    stat_o.sel_b     = sel_b_q;
  end

  assign res_o = res_q;

endmodule

/* rtl/core/union_find_cycle_tracking.sv */
// Top level of the union-find engine with per-set cycle marks.
//
//   channel   signals                                    direction
//   in        in_valid_i / in_ready_o, command, nodes    item in
//   out       out_valid_o / out_ready_i, result fields   item out
//   cfg       cfg_we_i, cfg_wdata_i (elements in use)    write only
//
// A find walks the parent chain to its root and then compresses that path; a merge does both
// for each node, then joins the roots or marks a cycle if they match; an unused code gives a
// zero result; a clear writes one node per cycle, N = elements in use capped at table size.
// Tables are not cleared by reset; a clear command initializes them.
// One item is in work at a time; the output register lets the next item enter while
// the previous result waits, and the sequencer holds at its last step if both are full.
module union_find_cycle_tracking
  import ufct_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  input  logic [NODE_W-1:0] node_a_i,
  input  logic [NODE_W-1:0] node_b_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [NODE_W-1:0] root_o,
  output logic              root_has_cycle_o,
  output logic [SIZE_W-1:0] set_size_o,
  output logic              already_joined_o,
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);

  ctrl_t ctrl;
  stat_t stat;
  res_t  res;
  logic  idle, load, out_busy, out_load;
  logic  out_valid_q, out_valid_d;
  res_t  out_q;

  assign in_ready_o = idle;
  assign load       = in_valid_i && idle;
  assign out_busy   = out_valid_q && !out_ready_i;
  assign out_load   = (ctrl.op == OP_DELIVER) && !out_busy;

  ufct_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_valid_i),
    .out_busy_i (out_busy),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .idle_o     (idle)
  );

  ufct_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .command_i   (command_i),
    .node_a_i    (node_a_i),
    .node_b_i    (node_b_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign root_o           = out_q.root;
  assign root_has_cycle_o = out_q.cyc;
  assign set_size_o       = out_q.size;
  assign already_joined_o = out_q.joined;

endmodule
